// ===== hdl/dlny_pkg.sv =====
// Package for the Delannoy number table block.
// Holds the sizes, the transaction payload types and the controller/datapath
// command and status structs. No dependencies.
package dlny_pkg;

   localparam int COORD_W   = 7;
   localparam int MAX_COORD = 127;
   localparam int VALUE_W   = 64;
   localparam int ROW_DEPTH = MAX_COORD + 1;
   localparam int ADDR_W    = $clog2(ROW_DEPTH);

   // Input transaction
   typedef struct packed {
      logic [COORD_W-1:0] row_coord;
      logic [COORD_W-1:0] col_coord;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [VALUE_W-1:0] delannoy_value;
      logic               wrapped;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // capture a new query, reset the walk
      logic step;   // compute one table cell
      logic emit;   // move the answer to the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic trivial;    // one coordinate is zero, answer is 1
      logic last_cell;  // current cell is the final one of the query
      logic out_free;   // output register can take a result this cycle
   } sts_type;

   // Coordinates above the table size saturate
   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (int'(v) > MAX_COORD) begin
         r = COORD_W'(MAX_COORD);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hdl/dlny_dpath.sv =====
// Datapath of the Delannoy number block: query registers, cell walk counters,
// row memory, three-way adder with carry tracking and the output register.
// Depends on dlny_pkg.
module dlny_dpath (
   input  logic              clock,
   input  logic              reset,
   input  dlny_pkg::cmd_type cmd,
   output dlny_pkg::sts_type sts,
   input  dlny_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dlny_pkg::rsp_type rsp_data
);

   localparam int VW = dlny_pkg::VALUE_W;
   localparam int CW = dlny_pkg::COORD_W;
   localparam int AW = dlny_pkg::ADDR_W;

   // query and walk state
   logic [CW-1:0] rows_ff, rows_in;
   logic [CW-1:0] cols_ff, cols_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [VW-1:0] diag_ff, diag_in;
   logic [VW-1:0] left_ff, left_in;
   logic          wrap_ff, wrap_in;

   // row store, one write and one registered read per cycle
   logic [VW-1:0] row_store_ff [dlny_pkg::ROW_DEPTH];
   logic [VW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   dlny_pkg::rsp_type rsp_data_ff;

   // cell arithmetic
   logic [CW-1:0] m_clamp, n_clamp;
   logic          row_end;
   logic [VW-1:0] up;
   logic [VW:0]   part;
   logic [VW:0]   sum;

   assign m_clamp = dlny_pkg::clamp_coord(req_data.row_coord);
   assign n_clamp = dlny_pkg::clamp_coord(req_data.col_coord);

   assign row_end = (col_ff == cols_ff);
   // row 0 of the table is all ones, so the first computed row never reads memory
   assign up      = (row_ff == CW'(1)) ? VW'(1) : rd_ff;
   assign part    = {1'b0, up} + {1'b0, left_ff};
   assign sum     = {1'b0, part[VW-1:0]} + {1'b0, diag_ff};

   assign wr_addr = AW'(col_ff);
   // read ahead: next cell's upper neighbor
   assign rd_addr = row_end ? AW'(1) : AW'(col_ff + CW'(1));

   // next state of the walk
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      diag_in = diag_ff;
      left_in = left_ff;
      wrap_in = wrap_ff;
      if (cmd.load) begin
         rows_in = (m_clamp > n_clamp) ? m_clamp : n_clamp;
         cols_in = (m_clamp > n_clamp) ? n_clamp : m_clamp;
         row_in  = CW'(1);
         col_in  = CW'(1);
         diag_in = VW'(1);
         left_in = VW'(1);
         wrap_in = 1'b0;
      end else if (cmd.step) begin
         wrap_in = wrap_ff | part[VW] | sum[VW];
         if (row_end) begin
            row_in  = row_ff + CW'(1);
            col_in  = CW'(1);
            diag_in = VW'(1);
            // left border is 1; the last cell's sum stays as the answer
            left_in = (row_ff == rows_ff) ? sum[VW-1:0] : VW'(1);
         end else begin
            col_in  = col_ff + CW'(1);
            diag_in = up;
            left_in = sum[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      cols_ff <= cols_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      diag_ff <= diag_in;
      left_ff <= left_in;
      wrap_ff <= wrap_in;
   end

   // row memory with write-through on a same-address read
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         row_store_ff[wr_addr] <= sum[VW-1:0];
      end
      if (cmd.step && (rd_addr == wr_addr)) begin
         rd_ff <= sum[VW-1:0];
      end else begin
         rd_ff <= row_store_ff[rd_addr];
      end
   end

   // output register
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.delannoy_value <= left_ff;
         rsp_data_ff.wrapped        <= wrap_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status
   assign sts.trivial   = (rows_ff == '0) || (cols_ff == '0);
   assign sts.last_cell = (row_ff == rows_ff) && row_end;
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;

endmodule

// ===== hdl/dlny_ctrl.sv =====
// Controller of the Delannoy number block: accepts a query, steps the
// datapath through every table cell and hands the answer to the output.
// Depends on dlny_pkg.
module dlny_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output dlny_pkg::cmd_type cmd,
   input  dlny_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // commands and next state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.trivial) begin
               state_in = ST_EMIT;
            end else begin
               cmd.step = 1'b1;
               if (sts.last_cell) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== hdl/delannoy_number_table_dp.sv =====
// Delannoy number block, top level.
// Each request transaction carries lattice coordinates (m, n); the block
// answers with one response transaction holding D(m, n) modulo 2^64 and a
// flag that is set if any table sum of that query carried out of 64 bits.
// Both channels use valid/ready; a transaction moves on a clock edge where
// valid and ready are both high.
// The table is walked one cell per cycle with a single 64-bit adder path
// and a 128-entry row memory; a query with R = max(m,n), C = min(m,n)
// covers R*C table cells (none if either coordinate is zero), and the
// answer is then loaded into the output register, which raises rsp_valid.
// Only one query is in work at a time; req_ready is high while the block is
// idle, so the next query is taken only after the last answer has moved to
// the output register. A finished response waits in the output register,
// and the next request is taken while it waits; if the receiver stalls, the
// following answer holds in the datapath until the output register frees.
// Reset (synchronous, active high) returns the block to idle and drops
// rsp_valid; the row memory needs no clearing, each query writes every entry
// it later reads.
// Depends on dlny_pkg, dlny_ctrl and dlny_dpath.
module delannoy_number_table_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dlny_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dlny_pkg::rsp_type rsp_data
);

   dlny_pkg::cmd_type cmd;
   dlny_pkg::sts_type sts;

   dlny_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dlny_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
